// File: src/apli_pkg.sv
package apli_pkg;

	localparam int TABLE_DEPTH_DEF = 512;
	localparam int TURN            = 23040;
	localparam int LOSS_CAP        = 25600;
	localparam int LOSS_FLOOR      = -65536;
	localparam int DIV_W           = 34;
	localparam int CNT_W           = 10;

	localparam logic [1:0] CMD_WR_H  = 2'd0;
	localparam logic [1:0] CMD_WR_V  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic REG_HPTS = 1'b0;
	localparam logic REG_VPTS = 1'b1;

	typedef struct packed {
		logic [14:0]        angle;
		logic signed [15:0] loss;
	} apli_entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_RD_LAST,
		ST_CLASSIFY,
		ST_SCAN,
		ST_MUL,
		ST_DIV_INIT,
		ST_DIV,
		ST_ACCUM,
		ST_PLANE_END,
		ST_DONE
	} apli_state_t;

	typedef enum logic [1:0] {
		RS_FIRST,
		RS_LAST,
		RS_ONE,
		RS_NEXT
	} apli_rsel_t;

	typedef struct packed {
		logic       clr_en;
		logic       wr_en;
		logic       q_load;
		apli_rsel_t rd_sel;
		logic       e0_load;
		logic       classify;
		logic       scan_step;
		logic       mul;
		logic       div_init;
		logic       div_step;
		logic       accum;
		logic       plane_next;
		logic       out_load;
	} apli_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic n_zero;
		logic needs_scan;
		logic scan_hit;
		logic div_last;
		logic plane_v;
		logic out_free;
	} apli_sts_t;

endpackage

// File: src/apli_ctrl.sv
module apli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_cmd,
	output logic              in_ready,
	input  apli_pkg::apli_sts_t sts,
	output apli_pkg::apli_cmd_t ctl
);

	apli_pkg::apli_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= apli_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			apli_pkg::ST_CLEAR:     if (sts.clr_last) state_d = apli_pkg::ST_IDLE;
			apli_pkg::ST_IDLE: begin
				if (in_valid && in_cmd == apli_pkg::CMD_QUERY) state_d = apli_pkg::ST_START;
			end
			apli_pkg::ST_START: begin
				if (sts.n_zero) state_d = apli_pkg::ST_PLANE_END;
				else            state_d = apli_pkg::ST_RD_LAST;
			end
			apli_pkg::ST_RD_LAST:   state_d = apli_pkg::ST_CLASSIFY;
			apli_pkg::ST_CLASSIFY: begin
				if (sts.needs_scan) state_d = apli_pkg::ST_SCAN;
				else                state_d = apli_pkg::ST_MUL;
			end
			apli_pkg::ST_SCAN:      if (sts.scan_hit) state_d = apli_pkg::ST_MUL;
			apli_pkg::ST_MUL:       state_d = apli_pkg::ST_DIV_INIT;
			apli_pkg::ST_DIV_INIT:  state_d = apli_pkg::ST_DIV;
			apli_pkg::ST_DIV:       if (sts.div_last) state_d = apli_pkg::ST_ACCUM;
			apli_pkg::ST_ACCUM:     state_d = apli_pkg::ST_PLANE_END;
			apli_pkg::ST_PLANE_END: begin
				if (sts.plane_v) state_d = apli_pkg::ST_DONE;
				else             state_d = apli_pkg::ST_START;
			end
			apli_pkg::ST_DONE:      if (sts.out_free) state_d = apli_pkg::ST_IDLE;
			default:                state_d = apli_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl      = '0;
		ctl.rd_sel = apli_pkg::RS_FIRST;
		in_ready = 1'b0;
		case (state_q)
			apli_pkg::ST_CLEAR: ctl.clr_en = 1'b1;
			apli_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.wr_en = in_valid &&
					(in_cmd == apli_pkg::CMD_WR_H || in_cmd == apli_pkg::CMD_WR_V);
				ctl.q_load = in_valid && in_cmd == apli_pkg::CMD_QUERY;
			end
			apli_pkg::ST_START:    ctl.rd_sel = apli_pkg::RS_FIRST;
			apli_pkg::ST_RD_LAST: begin
				ctl.e0_load = 1'b1;
				ctl.rd_sel  = apli_pkg::RS_LAST;
			end
			apli_pkg::ST_CLASSIFY: begin
				ctl.classify = 1'b1;
				ctl.rd_sel   = apli_pkg::RS_ONE;
			end
			apli_pkg::ST_SCAN: begin
				ctl.scan_step = 1'b1;
				ctl.rd_sel    = apli_pkg::RS_NEXT;
			end
			apli_pkg::ST_MUL:       ctl.mul = 1'b1;
			apli_pkg::ST_DIV_INIT:  ctl.div_init = 1'b1;
			apli_pkg::ST_DIV:       ctl.div_step = 1'b1;
			apli_pkg::ST_ACCUM:     ctl.accum = 1'b1;
			apli_pkg::ST_PLANE_END: ctl.plane_next = !sts.plane_v;
			apli_pkg::ST_DONE:      ctl.out_load = sts.out_free;
			default: ;
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> sts.out_free) else $error("result loaded over a pending one");
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.q_load |=> state_q == apli_pkg::ST_START) else $error("query did not start");
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apli_pkg::ST_CLEAR |-> !in_ready && !ctl.wr_en)
		else $error("item taken during clear");

endmodule

// File: src/apli_dp.sv
module apli_dp #(
	parameter int TABLE_DEPTH = apli_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  apli_pkg::apli_cmd_t        ctl,
	output apli_pkg::apli_sts_t        sts,
	input  logic [1:0]                 cmd,
	input  logic [8:0]                 entry_index,
	input  logic [14:0]                entry_angle,
	input  logic signed [15:0]         entry_loss,
	input  logic signed [15:0]         azimuth_angle,
	input  logic signed [15:0]         elevation_angle,
	input  logic [apli_pkg::CNT_W-1:0] hpts,
	input  logic [apli_pkg::CNT_W-1:0] vpts,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [16:0]         total_loss
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = apli_pkg::DIV_W;
	localparam int QCW = $clog2(DW);

	apli_pkg::apli_entry_t mem_h [TABLE_DEPTH];
	apli_pkg::apli_entry_t mem_v [TABLE_DEPTH];
	apli_pkg::apli_entry_t rd_h_q, rd_v_q, rd, e0_q, wr_entry;

	logic [AW-1:0] clr_cnt_q, waddr, raddr, scan_i_q, n_m1;
	logic [NW-1:0] n_cur;
	logic          we_h, we_v, idx_ok;
	logic [31:0]   idx32;

	logic [14:0]  xh_q, xv_q, x_cur;
	logic         plane_q;
	logic signed [16:0] a1_q, a2_q;
	logic signed [15:0] l1_q, l2_q;
	logic signed [34:0] prod_q;
	logic signed [17:0] den_q;
	logic               zspan_q, neg_q;
	logic [DW-1:0]      quo_q;
	logic [17:0]        dvs_q, rem_q;
	logic [QCW-1:0]     dcnt_q;
	logic signed [35:0] acc_q;
	logic               out_valid_q;
	logic signed [16:0] total_q;

	function automatic logic [14:0] wrap_neg(input logic signed [15:0] v);
		logic signed [17:0] t;
		t = 18'(v);
		if (t >= -18'sd23040) t = t + 18'sd23040;
		else                  t = t + 18'sd46080;
		return t[14:0];
	endfunction

	function automatic logic [NW-1:0] clip_n(input logic [apli_pkg::CNT_W-1:0] c);
		if (32'(c) > TABLE_DEPTH) return NW'(TABLE_DEPTH);
		return NW'(c);
	endfunction

	// table write / clear
	always_comb begin
		idx32    = 32'(entry_index);
		idx_ok   = idx32 < TABLE_DEPTH;
		wr_entry.angle = (32'(entry_angle) >= apli_pkg::TURN) ?
			15'(32'(entry_angle) - apli_pkg::TURN) : entry_angle;
		wr_entry.loss  = entry_loss;
		if (ctl.clr_en) begin
			wr_entry = '0;
			waddr    = clr_cnt_q;
		end else begin
			waddr    = idx32[AW-1:0];
		end
		we_h = ctl.clr_en || (ctl.wr_en && idx_ok && cmd == apli_pkg::CMD_WR_H);
		we_v = ctl.clr_en || (ctl.wr_en && idx_ok && cmd == apli_pkg::CMD_WR_V);
	end

	always_comb begin
		n_cur = plane_q ? clip_n(vpts) : clip_n(hpts);
		n_m1  = AW'(n_cur - NW'(1));
		x_cur = plane_q ? xv_q : xh_q;
		rd    = plane_q ? rd_v_q : rd_h_q;
		case (ctl.rd_sel)
			apli_pkg::RS_FIRST: raddr = '0;
			apli_pkg::RS_LAST:  raddr = n_m1;
			apli_pkg::RS_ONE:   raddr = AW'(1);
			apli_pkg::RS_NEXT:  raddr = scan_i_q + AW'(1);
			default:            raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_h) mem_h[waddr] <= wr_entry;
		if (we_v) mem_v[waddr] <= wr_entry;
		rd_h_q <= mem_h[raddr];
		rd_v_q <= mem_v[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (ctl.clr_en) clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	// query datapath
	logic signed [16:0] dl;
	logic signed [17:0] dx;
	logic [34:0]        an;
	logic [17:0]        ad;
	logic [18:0]        trial;
	logic signed [35:0] pv;

	always_comb begin
		dl    = 17'(l2_q) - 17'(l1_q);
		dx    = $signed({3'b000, x_cur}) - 18'(a1_q);
		an    = prod_q[34] ? 35'(-prod_q) : 35'(prod_q);
		ad    = den_q[17] ? 18'(-den_q) : 18'(den_q);
		trial = {rem_q, quo_q[DW-1]};
		if (zspan_q)    pv = 36'(l1_q);
		else if (neg_q) pv = 36'(l1_q) - $signed({2'b00, quo_q});
		else            pv = 36'(l1_q) + $signed({2'b00, quo_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.q_load) begin
			if (azimuth_angle < 0) xh_q <= wrap_neg(azimuth_angle);
			else if (32'(azimuth_angle) >= apli_pkg::TURN)
				xh_q <= 15'(32'(azimuth_angle) - apli_pkg::TURN);
			else xh_q <= azimuth_angle[14:0];
			if (elevation_angle < 0) xv_q <= wrap_neg(elevation_angle);
			else if (32'(elevation_angle) > apli_pkg::TURN)
				xv_q <= 15'(32'(elevation_angle) - apli_pkg::TURN);
			else xv_q <= elevation_angle[14:0];
		end
		if (ctl.e0_load) e0_q <= rd;
		if (ctl.classify) begin
			if (x_cur < e0_q.angle) begin
				a1_q <= $signed({2'b00, rd.angle}) - 17'sd23040;
				l1_q <= rd.loss;
				a2_q <= $signed({2'b00, e0_q.angle});
				l2_q <= e0_q.loss;
			end else if (x_cur >= rd.angle) begin
				a1_q <= $signed({2'b00, rd.angle});
				l1_q <= rd.loss;
				a2_q <= $signed({2'b00, e0_q.angle}) + 17'sd23040;
				l2_q <= e0_q.loss;
			end else begin
				a1_q <= $signed({2'b00, e0_q.angle});
				l1_q <= e0_q.loss;
			end
			scan_i_q <= AW'(1);
		end
		if (ctl.scan_step) begin
			if (x_cur < rd.angle) begin
				a2_q <= $signed({2'b00, rd.angle});
				l2_q <= rd.loss;
			end else begin
				a1_q     <= $signed({2'b00, rd.angle});
				l1_q     <= rd.loss;
				scan_i_q <= scan_i_q + AW'(1);
			end
		end
		if (ctl.mul) begin
			prod_q  <= 35'(dl) * 35'(dx);
			den_q   <= 18'(a2_q) - 18'(a1_q);
			zspan_q <= a1_q == a2_q;
		end
		// rounded quotient: (2|num| + |den|) / (2|den|)
		if (ctl.div_init) begin
			quo_q  <= DW'({an[32:0], 1'b0}) + DW'(ad);
			dvs_q  <= {ad[16:0], 1'b0};
			rem_q  <= '0;
			neg_q  <= prod_q[34] ^ den_q[17];
			dcnt_q <= '0;
		end
		if (ctl.div_step) begin
			dcnt_q <= dcnt_q + QCW'(1);
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 18'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[17:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
		if (ctl.q_load)     acc_q <= '0;
		else if (ctl.accum) acc_q <= acc_q + pv;
		if (ctl.out_load) begin
			if (acc_q > 36'sd25600)       total_q <= 17'sd25600;
			else if (acc_q < -36'sd65536) total_q <= -17'sd65536;
			else                          total_q <= acc_q[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.q_load)          plane_q <= 1'b0;
			else if (ctl.plane_next) plane_q <= 1'b1;
			if (ctl.out_load)        out_valid_q <= 1'b1;
			else if (out_ready)      out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.clr_last   = clr_cnt_q == AW'(TABLE_DEPTH - 1);
		sts.n_zero     = n_cur == '0;
		sts.needs_scan = !(x_cur < e0_q.angle) && !(x_cur >= rd.angle);
		sts.scan_hit   = x_cur < rd.angle;
		sts.div_last   = dcnt_q == QCW'(DW - 1);
		sts.plane_v    = plane_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign total_loss = total_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_step |-> 32'(scan_i_q) < 32'(n_cur)) else $error("scan past last point");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(total_q))
		else $error("pending result changed");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_init |=> dcnt_q == '0) else $error("divider not restarted");

endmodule

// File: src/antenna_pattern_loss_interpolator.sv
// Channel   Handshake          Payload
// in        in_valid/in_ready  cmd, entry_index, entry_angle, entry_loss,
//                              azimuth_angle, elevation_angle
// out       out_valid/out_ready total_loss
// config    APB write/read     horizontal_points @0x0, vertical_points @0x4
//
// After reset both tables are zeroed one entry per cycle, with in_ready low
// (APB stays live). A query runs the two planes in turn; a non-empty plane
// does 3 reads, a scan of k table entries (up to n-1), a multiply, a 34-step
// serial divide, accumulate and plane end. An empty plane goes straight from
// start to plane end. A query keeps in_ready low until it has finished.
// The result sits in an output register; while it is not taken, the next query
// finishes and then waits in its last state with in_ready low for all commands.
module antenna_pattern_loss_interpolator #(
	parameter int TABLE_DEPTH = apli_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [8:0]         entry_index,
	input  logic [14:0]        entry_angle,
	input  logic signed [15:0] entry_loss,
	input  logic signed [15:0] azimuth_angle,
	input  logic signed [15:0] elevation_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] total_loss,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	apli_pkg::apli_cmd_t ctl;
	apli_pkg::apli_sts_t sts;

	logic [apli_pkg::CNT_W-1:0] hpts_q, vpts_q;

	// point-count registers, decoded on word address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpts_q <= '0;
			vpts_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == apli_pkg::REG_HPTS) hpts_q <= pwdata[apli_pkg::CNT_W-1:0];
			else                                vpts_q <= pwdata[apli_pkg::CNT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == apli_pkg::REG_HPTS) ? 32'(hpts_q) : 32'(vpts_q);

	apli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	apli_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cmd             (cmd),
		.entry_index     (entry_index),
		.entry_angle     (entry_angle),
		.entry_loss      (entry_loss),
		.azimuth_angle   (azimuth_angle),
		.elevation_angle (elevation_angle),
		.hpts            (hpts_q),
		.vpts            (vpts_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.total_loss      (total_loss)
	);

endmodule

// File: tb/sv/apli_checker.sv
`timescale 1ns / 1ps

module apli_checker
	import apli_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [8:0]         entry_index,
	input  logic [14:0]        entry_angle,
	input  logic signed [15:0] entry_loss,
	input  logic signed [15:0] azimuth_angle,
	input  logic signed [15:0] elevation_angle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [16:0] total_loss,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam int DEPTH = TABLE_DEPTH_DEF;

	apli_entry_t        h_pattern [DEPTH];
	apli_entry_t        v_pattern [DEPTH];
	logic [9:0]         h_count;
	logic [9:0]         v_count;
	logic signed [16:0] loss_queue [$];

	assign pending = loss_queue.size();

	// nearest, ties away from zero
	function automatic longint div_round(input longint num, input longint den);
		longint an;
		longint ad;
		longint q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint interp_plane(input bit vert, input int x);
		int n;
		int a1, a2, l1, l2;
		apli_entry_t first, last, cur, prev;
		n = vert ? v_count : h_count;
		if (n > DEPTH)
			n = DEPTH;
		if (n == 0)
			return 0;
		first = vert ? v_pattern[0] : h_pattern[0];
		last = vert ? v_pattern[n-1] : h_pattern[n-1];
		a1 = 0; a2 = 0; l1 = 0; l2 = 0;
		if (x < int'(first.angle)) begin
			a1 = int'(last.angle) - TURN;
			a2 = first.angle;
			l1 = last.loss;
			l2 = first.loss;
		end else if (x >= int'(last.angle)) begin
			a1 = last.angle;
			a2 = int'(first.angle) + TURN;
			l1 = last.loss;
			l2 = first.loss;
		end else begin
			for (int i = 1; i < n; i++) begin
				cur = vert ? v_pattern[i] : h_pattern[i];
				if (x < int'(cur.angle)) begin
					prev = vert ? v_pattern[i-1] : h_pattern[i-1];
					a1 = prev.angle;
					a2 = cur.angle;
					l1 = prev.loss;
					l2 = cur.loss;
					break;
				end
			end
		end
		if (a2 == a1)
			return l1;
		return longint'(l1) + div_round(longint'(l2 - l1) * longint'(x - a1),
			longint'(a2 - a1));
	endfunction

	function automatic logic signed [16:0] predict_loss(input logic signed [15:0] az,
			input logic signed [15:0] el);
		int h;
		int v;
		longint sum;
		h = int'(az) % TURN;
		if (h < 0)
			h += TURN;
		v = el;
		if (v < 0) begin
			v = v % TURN;
			if (v < 0)
				v += TURN;
		end else if (v > TURN) begin
			v = ((v - 1) % TURN) + 1;
		end
		sum = interp_plane(1'b0, h) + interp_plane(1'b1, v);
		if (sum > LOSS_CAP)
			sum = LOSS_CAP;
		if (sum < LOSS_FLOOR)
			sum = LOSS_FLOOR;
		return sum[16:0];
	endfunction

	function automatic apli_entry_t make_entry(input logic [14:0] ang,
			input logic signed [15:0] loss);
		apli_entry_t e;
		e.angle = (ang >= TURN) ? ang - 15'(TURN) : ang;
		e.loss = loss;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				h_pattern[i] = '0;
				v_pattern[i] = '0;
			end
			h_count = '0;
			v_count = '0;
			fail_count = 0;
			checked = 0;
			loss_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_HPTS)
					h_count = pwdata[9:0];
				else
					v_count = pwdata[9:0];
			end
			if (in_valid && in_ready) begin
				case (cmd)
					CMD_WR_H: if (entry_index < DEPTH)
						h_pattern[entry_index] = make_entry(entry_angle, entry_loss);
					CMD_WR_V: if (entry_index < DEPTH)
						v_pattern[entry_index] = make_entry(entry_angle, entry_loss);
					CMD_QUERY: loss_queue.push_back(predict_loss(azimuth_angle,
						elevation_angle));
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (loss_queue.size() == 0) begin
					$error("total_loss: unexpected transaction, actual %0d", total_loss);
					fail_count++;
				end else begin
					if (total_loss !== loss_queue[0]) begin
						$error("total_loss expected %0d actual %0d", loss_queue[0],
							total_loss);
						fail_count++;
					end
					void'(loss_queue.pop_front());
					checked++;
				end
			end
		end
	end

endmodule

// File: tb/sv/tb_antenna_pattern_loss_interpolator.sv
`timescale 1ns / 1ps

module tb_antenna_pattern_loss_interpolator;
	import apli_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;  // unused code, must be dropped
	localparam int STALL_LIMIT = 20000;    // idle cycles before giving up
	localparam int HOLD_CYCLES = 400;      // long receiver hold-off

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [8:0]         entry_index;
	logic [14:0]        entry_angle;
	logic signed [15:0] entry_loss;
	logic signed [15:0] azimuth_angle;
	logic signed [15:0] elevation_angle;
	logic               out_valid;
	logic               out_ready;
	logic signed [16:0] total_loss;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int fail_count;
	int pending;
	int checked;
	int queries_sent;
	int idle_cycles;
	bit calm;       // no idling on either side once set
	bit hold_req;   // asks the receiver for one long hold-off

	antenna_pattern_loss_interpolator dut (.*);

	apli_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: any cycle that moves a transaction resets the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("antenna_pattern_loss_interpolator: mismatch");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Receiver: random stall bursts, one long hold-off on request, none when calm.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else
				out_ready = 1'b1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	// in_valid stays high on return so back-to-back items need no drop.
	task automatic send_item(input logic [1:0] c, input logic [8:0] idx,
			input logic [14:0] ang, input logic signed [15:0] loss,
			input logic signed [15:0] az, input logic signed [15:0] el);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		cmd = c;
		entry_index = idx;
		entry_angle = ang;
		entry_loss = loss;
		azimuth_angle = az;
		elevation_angle = el;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (c == CMD_QUERY)
			queries_sent++;
		@(negedge clk);
	endtask

	task automatic query(input logic signed [15:0] az, input logic signed [15:0] el);
		send_item(CMD_QUERY, 9'($urandom), 15'($urandom), 16'($urandom), az, el);
	endtask

	task automatic load_point(input logic [1:0] c, input logic [8:0] idx,
			input logic [14:0] ang, input logic signed [15:0] loss);
		send_item(c, idx, ang, loss, 16'($urandom), 16'($urandom));
	endtask

	// Drain all results, then let the last write settle before touching registers.
	task automatic drain;
		in_valid = 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic reg_write(input logic reg_sel, input logic [31:0] value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {reg_sel, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_counts(input logic [9:0] hn, input logic [9:0] vn);
		drain();
		reg_write(REG_HPTS, 32'(hn));
		reg_write(REG_VPTS, 32'(vn));
	endtask

	// Sorted pattern with random spacing; zero steps give equal angles.
	// A scrambled pattern exercises the unsorted behavior.
	task automatic fill_pattern(input logic [1:0] c, input int n, input bit scrambled);
		int a;
		int step_max;
		step_max = (n > 0) ? (TURN - 1) / n : 0;
		a = $urandom_range(0, step_max);
		for (int i = 0; i < n; i++) begin
			if (scrambled)
				load_point(c, 9'(i), 15'($urandom), 16'($urandom));
			else begin
				load_point(c, 9'(i), 15'(a), 16'($urandom));
				a += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
			end
		end
	endtask

	// Query angle: mostly any value, sometimes at turn boundaries.
	function automatic logic signed [15:0] pick_angle;
		case ($urandom_range(0, 5))
			0: return 16'(TURN * $urandom_range(0, 1) + $urandom_range(0, 2) - 1);
			1: return -16'(TURN) + 16'($urandom_range(0, 2) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_traffic(input int n_items);
		int r;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				query(pick_angle(), pick_angle());
			else if (r < 16)
				load_point(CMD_WR_H, 9'($urandom), 15'($urandom), 16'($urandom));
			else if (r < 19)
				load_point(CMD_WR_V, 9'($urandom), 15'($urandom), 16'($urandom));
			else
				send_item(CMD_NOP, 9'($urandom), 15'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int hn;
		int vn;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_NOP;
		entry_index = '0;
		entry_angle = '0;
		entry_loss = '0;
		azimuth_angle = '0;
		elevation_angle = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		queries_sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty tables contribute nothing.
		set_counts(10'd0, 10'd0);
		query(16'sh7fff, 16'sh8000);
		query(16'sd0, 16'sd23040);
		send_item(CMD_NOP, 9'h1ff, 15'h7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);

		// Loss extremes, an out-of-turn entry angle, last slot, equal angles.
		load_point(CMD_WR_H, 9'd0, 15'd0, 16'sh8000);
		load_point(CMD_WR_H, 9'd1, 15'd23039, 16'sh7fff);
		load_point(CMD_WR_H, 9'd2, 15'h7fff, 16'sh7fff);
		load_point(CMD_WR_H, 9'd511, 15'd100, 16'sh1234);
		load_point(CMD_WR_V, 9'd0, 15'd5000, 16'sh7fff);
		load_point(CMD_WR_V, 9'd1, 15'd5000, 16'sh8000);
		set_counts(10'd2, 10'd2);
		query(16'sd0, 16'sd0);           // horizontal at its minimum-loss point
		query(16'sd23039, 16'sd5000);    // opposite loss extremes, equal-angle pair
		query(16'sh8000, 16'sd23040);    // elevation kept at a full turn
		query(16'sd11520, 16'sd23041);   // elevation above a turn
		query(-16'sd1, -16'sd1);         // negative angles wrap
		set_counts(10'd3, 10'd1);        // unsorted horizontal, single vertical
		query(16'sd100, 16'sh7fff);
		query(16'sd23000, 16'sd4999);

		// Random phases: well-formed patterns with random content, some scrambled.
		for (int ph = 0; ph < 9; ph++) begin
			hn = $urandom_range(0, 16);
			vn = $urandom_range(0, 16);
			fill_pattern(CMD_WR_H, hn, $urandom_range(0, 5) == 0);
			fill_pattern(CMD_WR_V, vn, $urandom_range(0, 5) == 0);
			set_counts(10'(hn), 10'(vn));
			if (ph == 2) begin
				hold_req = 1'b1;   // receiver stalls; sender keeps offering queries
				for (int k = 0; k < 12; k++)
					query(pick_angle(), pick_angle());
			end
			if (ph == 8)
				calm = 1'b1;
			random_traffic(90);
		end

		// Full-depth scans: counts at the maximum and past the table depth.
		set_counts(10'd512, 10'h3ff);
		random_traffic(6);
		set_counts(10'h3ff, 10'd1);
		random_traffic(4);

		drain();
		repeat (50) @(negedge clk);
		$display("Covered %0d queries (%0d results checked) over empty, small,", queries_sent,
			checked);
		$display("scrambled and full-depth patterns with idling and a long output stall.");
		if (fail_count == 0 && pending == 0)
			$display("antenna_pattern_loss_interpolator: match");
		else
			$display("antenna_pattern_loss_interpolator: mismatch");
		$finish;
	end

endmodule

// File: files.f
src/apli_pkg.sv
src/apli_ctrl.sv
src/apli_dp.sv
src/antenna_pattern_loss_interpolator.sv
tb/sv/apli_checker.sv
tb/sv/tb_antenna_pattern_loss_interpolator.sv
